// ===== rtl/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

   localparam int WINDOW_DEPTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CARE_MASK    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LEN  = 2'd3;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic       shift;
      logic       active;
      logic       care;
      logic [7:0] pattern_byte;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/wildcard_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Finds the first place in a byte region where a masked pattern matches.
//
//   channel | ports                                   | direction
//   req     | req_valid req_ready req_data_byte       | in, one byte
//           | req_last_byte                           |
//   rsp     | rsp_valid rsp_ready rsp_found           | out, one per region
//           | rsp_match_offset                        |
//   csr     | csr_valid csr_ready csr_index csr_data  | in, register write
//
// one byte per cycle while req_ready is high; the window compare runs across the
// cell row in the cycle of the byte transfer and the result sits in the output register
// on the following cycle
// req_ready drops only while a result waits and rsp_ready is low
// synchronous reset clears the CSR registers, counter, reported flag and output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner
   import wbps_pkg::*;
#(
   parameter int PATTERN_MAX = 16
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_last_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_found,
   output logic [31:0]                     rsp_match_offset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [63:0]                csr_data
);

   localparam int CELLS = (PATTERN_MAX < WINDOW_DEPTH) ? PATTERN_MAX : WINDOW_DEPTH;

   logic [63:0]  pattern_low_ff, pattern_low_in;
   logic [63:0]  pattern_high_ff, pattern_high_in;
   logic [15:0]  care_ff, care_in;
   logic [4:0]   length_ff, length_in;
   logic [31:0]  seen_ff, seen_in;
   logic         reported_ff, reported_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         found_ff, found_in;
   logic [31:0]  offset_ff, offset_in;

   logic         accept;
   logic         shift;
   logic         length_ok;
   logic         match;
   logic         emit;
   logic [31:0]  count_next;
   logic [127:0] pattern_all;

   logic [7:0]   link [CELLS];
   logic [CELLS-1:0] cell_ok;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;
   assign accept     = req_valid && req_ready;
   assign shift      = accept && !reported_ff;
   assign count_next = (seen_ff == COUNT_MAX) ? COUNT_MAX : seen_ff + 32'd1;
   assign length_ok  = (length_ff != 5'd0) && (int'(length_ff) <= CELLS);
   assign match      = shift && length_ok && (count_next >= {27'd0, length_ff}) && (&cell_ok);
   assign emit       = shift && (match || req_last_byte);
   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   assign link[0] = req_data_byte;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic [4:0]    k;
      cell_ctrl_type ctrl;

      assign k                 = length_ff - 5'(i) - 5'd1;
      assign ctrl.shift        = shift;
      assign ctrl.active       = 5'(i) < length_ff;
      assign ctrl.care         = care_ff[k[3:0]];
      assign ctrl.pattern_byte = pattern_all[{k[3:0], 3'b000} +: 8];

      if (i < CELLS - 1) begin : g_mid
         wbps_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .link_byte (link[i]),
            .held_byte (link[i+1]),
            .byte_ok   (cell_ok[i])
         );
      end else begin : g_end
         wbps_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .link_byte (link[i]),
            .held_byte (),
            .byte_ok   (cell_ok[i])
         );
      end
   end

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      care_in         = care_ff;
      length_in       = length_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_in  = csr_data;
            CSR_PATTERN_HIGH: pattern_high_in = csr_data;
            CSR_CARE_MASK:    care_in         = csr_data[15:0];
            CSR_PATTERN_LEN:  length_in       = csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      seen_in     = seen_ff;
      reported_in = reported_ff;
      if (accept && req_last_byte) begin
         seen_in     = 32'd0;
         reported_in = 1'b0;
      end else if (shift) begin
         seen_in     = count_next;
         reported_in = match;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      offset_in    = offset_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         found_in     = match;
         offset_in    = match ? count_next - {27'd0, length_ff} : 32'd0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_ff         <= '0;
         length_ff       <= '0;
         seen_ff         <= '0;
         reported_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         care_ff         <= care_in;
         length_ff       <= length_in;
         seen_ff         <= seen_in;
         reported_ff     <= reported_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_match_offset = offset_ff;

endmodule

`default_nettype wire

// ===== rtl/wbps_cell.sv =====
// ----------------------------------------------------------------------------
// wbps_cell
// One window position: holds a byte, passes it on each shift and checks the
// byte entering it against its pattern byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell
   import wbps_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic [7:0]    link_byte,
   output logic [7:0]         held_byte,
   output logic               byte_ok
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   assign byte_in   = ctrl.shift ? link_byte : byte_ff;
   assign held_byte = byte_ff;
   assign byte_ok   = !ctrl.active || !ctrl.care || (link_byte == ctrl.pattern_byte);

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

// ===== rtl/wbps_checker.sv =====
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks for the wildcard byte pattern scanner, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbps_checker
   import wbps_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_found,
   input wire logic [31:0]                rsp_match_offset,
   input wire logic                       csr_valid,
   input wire logic                       csr_ready,
   input wire logic [CSR_INDEX_WIDTH-1:0] csr_index
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_match_offset))
      else $error("result changed while stalled");

   // not-found carries a zero offset
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == 32'd0)
      else $error("not-found result with nonzero offset");

   // a new result follows a byte transfer
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without a preceding byte transfer");

   // input only stalls behind a waiting result
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with free output register");

   // writes to the pattern length register never stall
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == CSR_PATTERN_LEN |-> csr_ready)
      else $error("register write stalled");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_found        (rsp_found),
   .rsp_match_offset (rsp_match_offset),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready),
   .csr_index        (csr_index)
);

`default_nettype wire
